// ----- hw/rtl/brtc_pkg.sv -----
// ----------------------------------------------------------------------------
// brtc_pkg: shared types, codes and helpers of the BCD clock register device
// Item and time-of-day types, action codes, register map and BCD helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package brtc_pkg;

    // Registers that carry the clock itself; any beyond these are plain storage.
    localparam int BASE_REGS = 8;
    localparam int BASE_AW   = 3;
    localparam int REG_COUNT_DEF = 8;

    // Action codes carried in tuser.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_PTR   = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Register map of the clock.
    localparam logic [BASE_AW-1:0] REG_SEC  = 3'd0;
    localparam logic [BASE_AW-1:0] REG_MIN  = 3'd1;
    localparam logic [BASE_AW-1:0] REG_HOUR = 3'd2;
    localparam logic [BASE_AW-1:0] REG_DOW  = 3'd3;
    localparam logic [BASE_AW-1:0] REG_DATE = 3'd4;
    localparam logic [BASE_AW-1:0] REG_MON  = 3'd5;
    localparam logic [BASE_AW-1:0] REG_YEAR = 3'd6;
    localparam logic [BASE_AW-1:0] REG_CTRL = 3'd7;

    localparam logic [7:0] RST_DOW  = 8'h01;
    localparam logic [7:0] RST_DATE = 8'h01;
    localparam logic [7:0] RST_MON  = 8'h01;
    localparam logic [7:0] RST_YEAR = 8'h25;

    localparam logic [7:0] SEC_WRAP  = 8'd60;
    localparam logic [7:0] MIN_WRAP  = 8'd60;
    localparam logic [7:0] HOUR_WRAP = 8'd24;
    localparam logic [7:0] DATE_MAX  = 8'd31;
    localparam logic [7:0] MON_MAX   = 8'd12;
    localparam logic [7:0] YEAR_MAX  = 8'd99;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] date;
        logic [7:0] mon;
        logic [7:0] year;
    } t_time;

    // High nibble times ten plus low nibble; nibbles above nine are not clamped.
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
    endfunction

    // Tens into the high nibble, units into the low one, truncated to a byte.
    // Division by ten uses the reciprocal 205/2048, exact for any byte.
    function automatic logic [7:0] bcd_code(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        prod = 16'(v) * 16'd205;
        quot = prod[15:11];
        rem  = v - 8'(quot) * 8'd10;
        return {quot[3:0], rem[3:0]};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/brtc_in_stage.sv -----
// ----------------------------------------------------------------------------
// brtc_in_stage: input register of the clock register device
// Holds one accepted beat until the processing stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module brtc_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire brtc_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_take,
    output brtc_pkg::t_item     o_item
);
    import brtc_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Free slot, or the held beat leaves in this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/brtc_tick.sv -----
// ----------------------------------------------------------------------------
// brtc_tick: one-second advance of the BCD time fields
// Decodes the six time fields, runs the rollover cascade and re-encodes.
// ----------------------------------------------------------------------------
`default_nettype none

module brtc_tick (
    input  wire brtc_pkg::t_time i_now,
    output brtc_pkg::t_time      o_next
);
    import brtc_pkg::*;

    logic [7:0] sec, min, hour, date, mon, year;

    always_comb begin
        sec  = bcd_value(i_now.sec) + 8'd1;
        min  = bcd_value(i_now.min);
        hour = bcd_value(i_now.hour);
        date = bcd_value(i_now.date);
        mon  = bcd_value(i_now.mon);
        year = bcd_value(i_now.year);

        if (sec >= SEC_WRAP) begin
            sec = 8'd0;
            min = min + 8'd1;
            if (min >= MIN_WRAP) begin
                min  = 8'd0;
                hour = hour + 8'd1;
                if (hour >= HOUR_WRAP) begin
                    hour = 8'd0;
                    date = date + 8'd1;
                    if (date > DATE_MAX) begin
                        date = 8'd1;
                        mon  = mon + 8'd1;
                    end
                    // The month is checked on every day change, so an
                    // out-of-range stored month also rolls the year.
                    if (mon > MON_MAX) begin
                        mon  = 8'd1;
                        year = year + 8'd1;
                        if (year > YEAR_MAX) begin
                            year = 8'd0;
                        end
                    end
                end
            end
        end

        o_next.sec  = bcd_code(sec);
        o_next.min  = bcd_code(min);
        o_next.hour = bcd_code(hour);
        o_next.date = bcd_code(date);
        o_next.mon  = bcd_code(mon);
        o_next.year = bcd_code(year);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/brtc_regs.sv -----
// ----------------------------------------------------------------------------
// brtc_regs: register file, pointer and result register
// Applies one item per cycle to the registers, unless a held result is not taken, and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module brtc_regs #(
    parameter int REG_COUNT = brtc_pkg::REG_COUNT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clk_en,
    input  wire logic            i_valid,
    input  wire brtc_pkg::t_item i_item,
    output logic                 o_take,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_read_data,
    output logic [7:0]           o_pointer_now
);
    import brtc_pkg::*;

    localparam int EXT   = (REG_COUNT > BASE_REGS) ? REG_COUNT - BASE_REGS : 1;
    localparam int EXT_W = (EXT > 1) ? $clog2(EXT) : 1;
    localparam logic [7:0] CNT      = 8'(REG_COUNT);
    localparam logic [7:0] CNT_LAST = 8'(REG_COUNT - 1);
    localparam logic [7:0] BASE     = 8'(BASE_REGS);

    logic [7:0] r_low [BASE_REGS];
    logic [7:0] r_ext [EXT];
    logic [EXT-1:0] r_ext_ok;
    logic [7:0] r_ptr;
    logic       r_ovalid;
    logic [7:0] r_rd;
    logic [7:0] r_ptr_out;

    t_time      now;
    t_time      nxt;
    logic [7:0] n_ptr;
    logic [7:0] n_rd;
    logic       in_file;
    logic       in_low;
    logic       ext_rd;
    logic       ext_we;
    logic       low_we;
    logic       tick_we;
    logic [7:0] ext_off;
    logic [EXT_W-1:0] ext_idx;

    assign now.sec  = r_low[REG_SEC];
    assign now.min  = r_low[REG_MIN];
    assign now.hour = r_low[REG_HOUR];
    assign now.date = r_low[REG_DATE];
    assign now.mon  = r_low[REG_MON];
    assign now.year = r_low[REG_YEAR];

    brtc_tick u_tick (
        .i_now  (now),
        .o_next (nxt)
    );

    assign o_take        = i_valid && (!r_ovalid || i_ready);
    assign o_valid       = r_ovalid;
    assign o_read_data   = r_rd;
    assign o_pointer_now = r_ptr_out;

    assign in_file = r_ptr < CNT;
    assign in_low  = r_ptr < BASE;
    assign ext_off = r_ptr - BASE;
    assign ext_idx = ext_off[EXT_W-1:0];

    always_comb begin
        n_ptr   = r_ptr;
        n_rd    = 8'd0;
        ext_rd  = 1'b0;
        ext_we  = 1'b0;
        low_we  = 1'b0;
        tick_we = 1'b0;
        case (i_item.action)
            ACT_TICK: begin
                tick_we = i_clk_en;
            end
            ACT_PTR: begin
                n_ptr = i_item.data;
            end
            ACT_WRITE: begin
                if (in_file) begin
                    low_we = in_low;
                    ext_we = !in_low;
                    n_ptr  = r_ptr + 8'd1;
                end
            end
            ACT_READ: begin
                if (in_file) begin
                    if (in_low) begin
                        n_rd = r_low[r_ptr[BASE_AW-1:0]];
                    end else begin
                        ext_rd = 1'b1;
                    end
                end
                // Reads stop at the last register.
                if (r_ptr < CNT_LAST) begin
                    n_ptr = r_ptr + 8'd1;
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_ptr    <= 8'd0;
            r_ext_ok <= '0;
            r_low[REG_SEC]  <= 8'd0;
            r_low[REG_MIN]  <= 8'd0;
            r_low[REG_HOUR] <= 8'd0;
            r_low[REG_DOW]  <= RST_DOW;
            r_low[REG_DATE] <= RST_DATE;
            r_low[REG_MON]  <= RST_MON;
            r_low[REG_YEAR] <= RST_YEAR;
            r_low[REG_CTRL] <= 8'd0;
        end else begin
            if (o_take) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_take) begin
                r_ptr <= n_ptr;
                if (low_we) begin
                    r_low[r_ptr[BASE_AW-1:0]] <= i_item.data;
                end
                if (ext_we) begin
                    r_ext_ok[ext_idx] <= 1'b1;
                end
                if (tick_we) begin
                    r_low[REG_SEC]  <= nxt.sec;
                    r_low[REG_MIN]  <= nxt.min;
                    r_low[REG_HOUR] <= nxt.hour;
                    r_low[REG_DATE] <= nxt.date;
                    r_low[REG_MON]  <= nxt.mon;
                    r_low[REG_YEAR] <= nxt.year;
                end
            end
        end
    end

    // Extra storage registers: a memory with a registered read into the
    // result register. Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            if (ext_we) begin
                r_ext[ext_idx] <= i_item.data;
            end
            if (ext_rd) begin
                r_rd <= r_ext_ok[ext_idx] ? r_ext[ext_idx] : 8'd0;
            end else begin
                r_rd <= n_rd;
            end
            r_ptr_out <= n_ptr;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bcd_rtc_register_device_unit.sv -----
// ----------------------------------------------------------------------------
// bcd_rtc_register_device_unit: BCD real-time clock with a byte register file
// Tick, pointer, write and read beats in; one result beat out for each.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries an action in s_axis_tuser and a byte in
// s_axis_tdata. A tick advances the BCD time by one second while the clock
// is enabled; a pointer beat loads the register pointer; a write beat stores
// the byte at the pointer and steps it on; a read beat returns the byte at
// the pointer and steps it on until the last register.
// Every input beat gives exactly one output beat on m_axis, with the byte
// read (zero for other actions) and the pointer after the beat.
// The enable is written through the cfg channel, which is always ready; it
// is meant to be changed only while no beats are in flight.
// A beat passes through two registers: the input register, then the result
// register. One beat is accepted every cycle while the receiver takes its
// results; the tick cascade between the two registers is combinational.
// When the receiver stalls, the result register holds its beat
// and the input register still takes one more beat before s_axis_tready
// falls. Reset (i_rst_n low, synchronous) sets the time to 00:00:00, day 1,
// 01/01, year 25, clears the pointer and control byte, and enables the clock.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_rtc_register_device_unit #(
    parameter int REG_COUNT = brtc_pkg::REG_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write: bit 0 is clock_enable.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [7:0] read_data, [15:8] pointer_now
);
    import brtc_pkg::*;

    logic  r_clk_en;
    t_item in_item;
    t_item held_item;
    logic  held_valid;
    logic  take;
    logic [7:0] read_data;
    logic [7:0] pointer_now;

    // The enable is a single flip-flop; writes complete in the cycle offered.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_clk_en <= i_cfg_data;
        end
    end

    assign in_item.action = s_axis_tuser;
    assign in_item.data   = s_axis_tdata;

    brtc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    brtc_regs #(
        .REG_COUNT (REG_COUNT)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clk_en      (r_clk_en),
        .i_valid       (held_valid),
        .i_item        (held_item),
        .o_take        (take),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_read_data   (read_data),
        .o_pointer_now (pointer_now)
    );

    assign m_axis_tdata = {pointer_now, read_data};

endmodule

`default_nettype wire
